// ----- src/hse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg: shared types for the sort engine
// Cell control and the slot record passed between neighboring cells.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic load;   // insert the broadcast value into the sorted row
    logic shift;  // drain: every cell takes its right neighbor's slot
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;  // slot holds an element
    logic   lt;     // broadcast value sorts before this slot (empty counts as +inf)
    value_t value;
  } slot_t;

endpackage

// ----- src/hse_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_cell: one slot of the insertion sort row
// Holds one element; on insert it keeps, takes the new value or takes the
// left neighbor's value; on drain it takes the right neighbor's value.
// ----------------------------------------------------------------------------
module hse_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  hse_pkg::cell_ctl_t ctl,
  input  hse_pkg::value_t    new_value,
  input  hse_pkg::slot_t     left,
  input  hse_pkg::slot_t     right,
  output hse_pkg::slot_t     own
);

  logic            valid_r;
  logic            valid_nxt;
  hse_pkg::value_t value_r;
  hse_pkg::value_t value_nxt;
  logic            lt;

  assign lt = !valid_r || (new_value < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.shift) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else if (ctl.load) begin
      // row is a prefix of valid slots, so the left valid bit grows it by one
      valid_nxt = valid_r | left.valid;
      if (lt) begin
        value_nxt = left.lt ? left.value : new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign own.valid = valid_r;
  assign own.lt    = lt;
  assign own.value = value_r;

endmodule

// ----- src/heap_sort_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine: ascending sort of a set of signed 32-bit values
// Loading: one input transfer per cycle while in_tready is high; each value is inserted in order into
//   a row of DEPTH cells in the cycle it arrives (the row is always sorted).
// Output: first result the cycle after the transfer marked last, then one
//   result per cycle while out_tready is high.
// No new set is taken while results drain. Reset clears the cell valid bits,
//   the state and the drop flag.
// ----------------------------------------------------------------------------
// Structure: a chain of DEPTH identical cells. The incoming value is broadcast
// to every cell; each cell compares it with its own element and either keeps
// its element, takes the new value, or takes its left neighbor's element, so
// the row shifts right past the insertion point. Empty cells act as +inf.
// Draining shifts the row left by one per output transfer; cell 0 is the
// output register. Items arriving while the row is full are discarded and set
// a sticky drop flag reported on every result of the set.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value_in
  input  logic        in_tlast,   // last_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic        out_tlast,  // last_out
  output logic        out_tuser   // [0] dropped
);

  // controller states
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic               state_r;
  logic               state_nxt;
  logic               drop_r;
  logic               drop_nxt;
  logic               in_xfer;
  logic               out_xfer;
  logic               row_full;
  hse_pkg::cell_ctl_t ctl;
  hse_pkg::value_t    new_value;
  hse_pkg::slot_t     slots [DEPTH];
  hse_pkg::slot_t     edge_left;
  hse_pkg::slot_t     edge_right;
  logic [DEPTH-1:0]   valid_vec;

  assign new_value = hse_pkg::value_t'(in_tdata);

  // boundary slots: left end is always "valid, not smaller", right end empty
  assign edge_left  = '{valid: 1'b1, lt: 1'b0, value: '0};
  assign edge_right = '{valid: 1'b0, lt: 1'b0, value: '0};

  assign in_tready = (state_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign row_full  = slots[DEPTH-1].valid;

  assign out_tvalid = (state_r == ST_DRAIN) && slots[0].valid;
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = slots[0].value;
  assign out_tlast  = !slots[1].valid;  // next cell empty: this is the final element
  assign out_tuser  = drop_r;

  assign ctl.load  = in_xfer && !row_full;
  assign ctl.shift = out_xfer;

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hse_pkg::slot_t left_slot;
    hse_pkg::slot_t right_slot;
    if (i == 0) begin : g_first
      assign left_slot = edge_left;
    end else begin : g_mid
      assign left_slot = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_slot = edge_right;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end
    hse_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_value (new_value),
      .left      (left_slot),
      .right     (right_slot),
      .own       (slots[i])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  // controller: load until the last transfer, then drain the row
  always_comb begin
    state_nxt = state_r;
    drop_nxt  = drop_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (row_full) begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer && out_tlast) begin
          state_nxt = ST_LOAD;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // occupied cells always form a run starting at cell 0
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & DEPTH'(valid_vec + 1'b1)) == '0)
    else $error("cell valid bits not a prefix");

  // cells 0 and 1 stay in sorted order
  a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (slots[0].valid && slots[1].valid) |-> (slots[0].value <= slots[1].value))
    else $error("cells 0 and 1 out of order");

  // input and output sides never open together
  a_side_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while results pending");

  // after the final result the row is empty and loading resumes
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (in_tready && (valid_vec == '0) && !out_tuser))
    else $error("row not cleared after final result");

  // a drain always has at least one element to send
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> out_tvalid)
    else $error("drain started with empty row");

endmodule
